### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with the common reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A property that must hold whenever a result word is offered.
`define ASSERT_ON_OUT(label, cons, msg) \
  `ASSERT_AT(label, out_valid_o |-> (cons), msg)

`endif

### sv/ream_pkg.sv
// ----------------------------------------------------------------------------
// ream_pkg
// Shared types, codes and constants of the resource event alarm monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ream_pkg;

  // Memory page size and counter width.
  localparam int unsigned PAGE_BITS = 12;
  localparam int unsigned KB_SHIFT  = PAGE_BITS - 10;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SUM_W     = ((CNT_W > 32) ? CNT_W : 32) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Field widths.
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SHARE_W = 10;
  localparam int unsigned REQ_W   = 4;
  localparam int unsigned EVT_W   = 3;
  localparam int unsigned LVL_W   = 2;

  // Busy share divider: one doubling and one add step per result bit.
  localparam logic [SHARE_W-1:0] PERMILLE = 10'd1000;
  localparam int unsigned DIV_STEPS   = 2 * SHARE_W;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);
  localparam int unsigned SHARE_IDX_W = $clog2(SHARE_W);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_HIGH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDERRUN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOV_FAIL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UART_DROP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT = 3'd5;

  // Event counter slots.
  localparam int unsigned NUM_CNT   = 9;
  localparam int unsigned CNT_IDX_W = $clog2(NUM_CNT);
  localparam logic [CNT_IDX_W-1:0] CNT_SAMPLE = 4'd0;
  localparam logic [CNT_IDX_W-1:0] CNT_CPU    = 4'd7;
  localparam logic [CNT_IDX_W-1:0] CNT_MEM    = 4'd8;

  // Alarm levels.
  localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LVL_W-1:0] LVL_WARN = 2'd1;
  localparam logic [LVL_W-1:0] LVL_CRIT = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE   = 4'd0,
    REQ_KEY_IRQ  = 4'd1,
    REQ_UART     = 4'd2,
    REQ_WAIT     = 4'd3,
    REQ_UNDERRUN = 4'd4,
    REQ_RECOV_OK = 4'd5,
    REQ_RECOV_FAIL = 4'd6,
    REQ_ACK      = 4'd7,
    REQ_CLEAR    = 4'd8
  } req_e;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE         = 3'd0,
    EVT_CPU_HIGH     = 3'd1,
    EVT_MEM_LOW      = 3'd2,
    EVT_UNDERRUN     = 3'd3,
    EVT_RECOV_FAIL   = 3'd4,
    EVT_UART_BACKLOG = 3'd5,
    EVT_WAIT_TIMEOUT = 3'd7
  } evt_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic delta;
    logic diff;
    logic div_dbl;
    logic div_add;
    logic commit;
  } ream_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_sample;
    logic usable;
  } ream_stat_t;

  // Saturating counter increment.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [WORD_W-1:0] amt);
    logic [SUM_W-1:0] s;
    s = SUM_W'(cnt) + SUM_W'(amt);
    if (s > SUM_W'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return CNT_W'(s);
  endfunction

endpackage

`default_nettype wire

### sv/resource_event_alarm_monitor.sv
// ----------------------------------------------------------------------------
// resource_event_alarm_monitor
// Resource monitor that counts system events and raises alarms on thresholds.
// ----------------------------------------------------------------------------
// The block takes one event word at a time and returns exactly one result
// word for it. Non-sample events (key IRQ, UART drop, wait timeout, audio
// underrun, recovery ok/fail, ack, clear) go from acceptance straight to the
// commit state. For a sample event the delta and diff states form the total
// and idle time deltas; when a valid CPU time delta exists, a 64-bit
// restoring divider then works out the busy permille with one doubling or
// one add step per cycle, 20 steps in all, before the commit state commits
// the result. The input is ready whenever the sequencer is idle, even while
// the previous result word still waits at the output; the next result is
// committed only once that word has been taken. Configuration is written
// through a plain write port and should only change while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_event_alarm_monitor import ream_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_W-1:0]     cfg_wdata_i,
  // Event word input.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [TIME_W-1:0]     total_time_i,
  input  logic [TIME_W-1:0]     idle_time_i,
  input  logic [PAGE_W-1:0]     free_pages_i,
  input  logic [PAGE_W-1:0]     buffer_pages_i,
  input  logic [WORD_W-1:0]     drop_bytes_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  // Result word output.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SHARE_W-1:0]    cpu_usage_permille_o,
  output logic [WORD_W-1:0]     mem_free_kb_o,
  output logic [WORD_W-1:0]     mem_available_kb_o,
  output logic                  event_pending_o,
  output logic [LVL_W-1:0]      alarm_level_o,
  output logic [EVT_W-1:0]      last_event_type_o,
  output logic [TIME_W-1:0]     last_event_ts_ms_o,
  output logic [EVT_W-1:0]      raised_event_o,
  output logic [WORD_W-1:0]     touched_count_o,
  output logic [WORD_W-1:0]     cpu_high_count_o,
  output logic [WORD_W-1:0]     mem_low_count_o
);

  ream_cmd_t  cmd;
  ream_stat_t stat;

  // The sequencer owns the handshakes and the divider step count.
  ream_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds all monitor state. Its state registers drive the
  // result fields directly; they change only on a commit, which happens
  // only when the output slot is free, so a waiting result stays stable.
  ream_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .req_type_i           (req_type_i),
    .total_time_i         (total_time_i),
    .idle_time_i          (idle_time_i),
    .free_pages_i         (free_pages_i),
    .buffer_pages_i       (buffer_pages_i),
    .drop_bytes_i         (drop_bytes_i),
    .now_ms_i             (now_ms_i),
    .cpu_usage_permille_o (cpu_usage_permille_o),
    .mem_free_kb_o        (mem_free_kb_o),
    .mem_available_kb_o   (mem_available_kb_o),
    .event_pending_o      (event_pending_o),
    .alarm_level_o        (alarm_level_o),
    .last_event_type_o    (last_event_type_o),
    .last_event_ts_ms_o   (last_event_ts_ms_o),
    .raised_event_o       (raised_event_o),
    .touched_count_o      (touched_count_o),
    .cpu_high_count_o     (cpu_high_count_o),
    .mem_low_count_o      (mem_low_count_o)
  );

endmodule

`default_nettype wire

### sv/ream_ctrl.sv
// ----------------------------------------------------------------------------
// ream_ctrl
// Sequencer: accepts a word, steps the datapath and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ream_ctrl import ream_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ream_stat_t stat_i,
  output ream_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DELTA  = 5'b00010,
    ST_DIFF   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     out_valid_q, out_valid_d;
  logic [SHARE_IDX_W-1:0]   bit_idx;

  // Bit of the constant 1000 handled by the current step pair, MSB first.
  assign bit_idx = SHARE_IDX_W'(SHARE_W - 1) - step_q[STEP_W-1:1];

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.in_sample ? ST_DELTA : ST_COMMIT;
        end
      end
      ST_DELTA: begin
        cmd_o.delta = 1'b1;
        state_d     = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        step_d     = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.usable) begin
          state_d = ST_COMMIT;
        end else begin
          if (!step_q[0]) begin
            cmd_o.div_dbl = 1'b1;
          end else begin
            cmd_o.div_add = PERMILLE[bit_idx];
          end
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_d = ST_COMMIT;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sv/ream_dpath.sv
// ----------------------------------------------------------------------------
// ream_dpath
// Datapath: CPU time deltas, permille divider, counters and alarm state.
// ----------------------------------------------------------------------------
`default_nettype none

module ream_dpath import ream_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ream_cmd_t             cmd_i,
  output ream_stat_t            stat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_W-1:0]     cfg_wdata_i,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [TIME_W-1:0]     total_time_i,
  input  logic [TIME_W-1:0]     idle_time_i,
  input  logic [PAGE_W-1:0]     free_pages_i,
  input  logic [PAGE_W-1:0]     buffer_pages_i,
  input  logic [WORD_W-1:0]     drop_bytes_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  output logic [SHARE_W-1:0]    cpu_usage_permille_o,
  output logic [WORD_W-1:0]     mem_free_kb_o,
  output logic [WORD_W-1:0]     mem_available_kb_o,
  output logic                  event_pending_o,
  output logic [LVL_W-1:0]      alarm_level_o,
  output logic [EVT_W-1:0]      last_event_type_o,
  output logic [TIME_W-1:0]     last_event_ts_ms_o,
  output logic [EVT_W-1:0]      raised_event_o,
  output logic [WORD_W-1:0]     touched_count_o,
  output logic [WORD_W-1:0]     cpu_high_count_o,
  output logic [WORD_W-1:0]     mem_low_count_o
);

  // Configuration.
  logic [SHARE_W-1:0] cfg_cpu_q;
  logic [WORD_W-1:0]  cfg_mem_q, cfg_under_q, cfg_rfail_q, cfg_uart_q, cfg_wait_q;

  // Captured input word.
  logic [REQ_W-1:0]  req_q;
  logic [TIME_W-1:0] tot_q, idl_q, now_q;
  logic [PAGE_W-1:0] fp_q, bp_q;
  logic [WORD_W-1:0] drop_q;

  // Delta and divider registers.
  logic [TIME_W-1:0]  prev_total_q, prev_idle_q;
  logic [TIME_W-1:0]  dt_q, di_q, a_q, rem_q;
  logic [SHARE_W-1:0] quo_q;
  logic               prev_ok_q, usable_q;

  // Architectural state.
  logic [CNT_W-1:0]   cnt_q [NUM_CNT];
  logic [SHARE_W-1:0] share_q;
  logic [WORD_W-1:0]  free_kb_q, avail_kb_q;
  logic               pending_q;
  logic [LVL_W-1:0]   level_q;
  evt_e               last_type_q;
  logic [TIME_W-1:0]  stamp_q;
  evt_e               raised_q;
  logic [WORD_W-1:0]  touched_q;

  // Combinational helpers.
  logic [TIME_W:0]       dt_full, dbl, add_sum, dbl_red, add_red;
  logic                  dbl_ge, add_ge;
  logic [SHARE_W-1:0]    share;
  logic [PAGE_W:0]       page_sum;
  logic [WORD_W-1:0]     free_kb, avail_kb;
  logic                  cpu_hit, mem_hit;
  logic [CNT_IDX_W-1:0]  bump_idx;
  logic [WORD_W-1:0]     amount, thr;
  logic [CNT_W-1:0]      bump_new, cpu_new, mem_new;
  logic                  count_en, thr_hit;
  evt_e                  raised;
  logic [LVL_W-1:0]      raised_lvl;

  assign stat_o.in_sample = (req_type_i == REQ_SAMPLE);
  assign stat_o.usable    = usable_q;

  // Total delta with borrow: a clear borrow and a nonzero delta mean the total grew.
  assign dt_full = {1'b0, tot_q} - {1'b0, prev_total_q};

  // Divider steps; the remainder always stays below the total delta.
  assign dbl     = {rem_q, 1'b0};
  assign dbl_ge  = (dbl >= {1'b0, dt_q});
  assign dbl_red = dbl - {1'b0, dt_q};
  assign add_sum = {1'b0, rem_q} + {1'b0, a_q};
  assign add_ge  = (add_sum >= {1'b0, dt_q});
  assign add_red = add_sum - {1'b0, dt_q};

  assign share    = usable_q ? quo_q : '0;
  assign page_sum = {1'b0, fp_q} + {1'b0, bp_q};
  assign free_kb  = WORD_W'(fp_q) << KB_SHIFT;
  assign avail_kb = WORD_W'(page_sum) << KB_SHIFT;
  assign cpu_hit  = (cfg_cpu_q != '0) && (share >= cfg_cpu_q);
  assign mem_hit  = (cfg_mem_q != '0) && (avail_kb <= cfg_mem_q);

  // Request codes up to recovery fail map one to one onto counter slots.
  assign bump_idx = {1'b0, req_q[2:0]};
  assign count_en = (req_q <= REQ_RECOV_FAIL);
  assign amount   = ((req_q == REQ_UART) && (drop_q != '0)) ? drop_q : WORD_W'(1);
  assign bump_new = sat_add(cnt_q[bump_idx], amount);
  assign cpu_new  = sat_add(cnt_q[CNT_CPU], WORD_W'(1));
  assign mem_new  = sat_add(cnt_q[CNT_MEM], WORD_W'(1));
  assign thr_hit  = (thr != '0) && (SUM_W'(bump_new) >= SUM_W'(thr));

  always_comb begin
    thr        = '0;
    raised     = EVT_NONE;
    raised_lvl = LVL_WARN;
    case (req_q)
      REQ_SAMPLE: begin
        if (mem_hit) begin
          raised = EVT_MEM_LOW;
        end else if (cpu_hit) begin
          raised = EVT_CPU_HIGH;
        end
      end
      REQ_UART: begin
        thr = cfg_uart_q;
        if (thr_hit) begin
          raised = EVT_UART_BACKLOG;
        end
      end
      REQ_WAIT: begin
        thr = cfg_wait_q;
        if (thr_hit) begin
          raised = EVT_WAIT_TIMEOUT;
        end
      end
      REQ_UNDERRUN: begin
        thr = cfg_under_q;
        if (thr_hit) begin
          raised = EVT_UNDERRUN;
        end
      end
      REQ_RECOV_FAIL: begin
        thr        = cfg_rfail_q;
        raised_lvl = LVL_CRIT;
        if (thr_hit) begin
          raised = EVT_RECOV_FAIL;
        end
      end
      default: begin
        raised = EVT_NONE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cpu_q   <= 10'd850;
      cfg_mem_q   <= 32'd16384;
      cfg_under_q <= 32'd1;
      cfg_rfail_q <= 32'd1;
      cfg_uart_q  <= 32'd1;
      cfg_wait_q  <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CPU_HIGH:     cfg_cpu_q   <= cfg_wdata_i[SHARE_W-1:0];
        CFG_MEM_LOW:      cfg_mem_q   <= cfg_wdata_i;
        CFG_UNDERRUN:     cfg_under_q <= cfg_wdata_i;
        CFG_RECOV_FAIL:   cfg_rfail_q <= cfg_wdata_i;
        CFG_UART_DROP:    cfg_uart_q  <= cfg_wdata_i;
        CFG_WAIT_TIMEOUT: cfg_wait_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input capture, deltas and divider.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      tot_q  <= total_time_i;
      idl_q  <= idle_time_i;
      fp_q   <= free_pages_i;
      bp_q   <= buffer_pages_i;
      drop_q <= drop_bytes_i;
      now_q  <= now_ms_i;
    end
    if (cmd_i.delta) begin
      dt_q      <= dt_full[TIME_W-1:0];
      di_q      <= idl_q - prev_idle_q;
      prev_ok_q <= (prev_total_q != '0) && !dt_full[TIME_W]
                   && (dt_full[TIME_W-1:0] != '0);
    end
    if (cmd_i.diff) begin
      a_q   <= dt_q - di_q;
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_dbl) begin
      rem_q <= dbl_ge ? dbl_red[TIME_W-1:0] : dbl[TIME_W-1:0];
      quo_q <= {quo_q[SHARE_W-2:0], dbl_ge};
    end
    if (cmd_i.div_add) begin
      rem_q <= add_ge ? add_red[TIME_W-1:0] : add_sum[TIME_W-1:0];
      quo_q <= quo_q + SHARE_W'(add_ge);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q <= 1'b0;
    end else if (cmd_i.diff) begin
      usable_q <= prev_ok_q && (dt_q > di_q);
    end
  end

  // Previous times, counters and alarm state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_total_q <= '0;
      prev_idle_q  <= '0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
      share_q     <= '0;
      free_kb_q   <= '0;
      avail_kb_q  <= '0;
      pending_q   <= 1'b0;
      level_q     <= LVL_NONE;
      last_type_q <= EVT_NONE;
      stamp_q     <= '0;
      raised_q    <= EVT_NONE;
      touched_q   <= '0;
    end else begin
      if (cmd_i.delta) begin
        prev_total_q <= tot_q;
        prev_idle_q  <= idl_q;
      end
      if (cmd_i.commit) begin
        case (req_q)
          REQ_SAMPLE: begin
            share_q           <= share;
            free_kb_q         <= free_kb;
            avail_kb_q        <= avail_kb;
            cnt_q[CNT_SAMPLE] <= bump_new;
            if (cpu_hit) begin
              cnt_q[CNT_CPU] <= cpu_new;
            end
            if (mem_hit) begin
              cnt_q[CNT_MEM] <= mem_new;
            end
          end
          REQ_KEY_IRQ, REQ_UART, REQ_WAIT, REQ_UNDERRUN, REQ_RECOV_OK,
          REQ_RECOV_FAIL: begin
            cnt_q[bump_idx] <= bump_new;
          end
          REQ_ACK: begin
            pending_q <= 1'b0;
            level_q   <= LVL_NONE;
          end
          REQ_CLEAR: begin
            for (int i = 0; i < NUM_CNT; i++) begin
              cnt_q[i] <= '0;
            end
            pending_q   <= 1'b0;
            level_q     <= LVL_NONE;
            last_type_q <= EVT_NONE;
            stamp_q     <= '0;
          end
          default: begin
          end
        endcase
        if (raised != EVT_NONE) begin
          pending_q   <= 1'b1;
          last_type_q <= raised;
          stamp_q     <= now_q;
          if (raised_lvl > level_q) begin
            level_q <= raised_lvl;
          end
        end
        raised_q  <= raised;
        touched_q <= count_en ? WORD_W'(bump_new) : '0;
      end
    end
  end

  assign cpu_usage_permille_o = share_q;
  assign mem_free_kb_o        = free_kb_q;
  assign mem_available_kb_o   = avail_kb_q;
  assign event_pending_o      = pending_q;
  assign alarm_level_o        = level_q;
  assign last_event_type_o    = last_type_q;
  assign last_event_ts_ms_o   = stamp_q;
  assign raised_event_o       = raised_q;
  assign touched_count_o      = touched_q;
  assign cpu_high_count_o     = WORD_W'(cnt_q[CNT_CPU]);
  assign mem_low_count_o      = WORD_W'(cnt_q[CNT_MEM]);

endmodule

`default_nettype wire

### sv/ream_chk.sv
// ----------------------------------------------------------------------------
// ream_chk
// Port level checks of the resource event alarm monitor, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ream_chk import ream_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               event_pending_o,
  input  logic [LVL_W-1:0]   alarm_level_o,
  input  logic [EVT_W-1:0]   last_event_type_o,
  input  logic [EVT_W-1:0]   raised_event_o,
  input  logic [WORD_W-1:0]  touched_count_o
);

  // A result word that is not taken stays offered and unchanged.
  `ASSERT_AT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(raised_event_o) && $stable(touched_count_o), "result word changed while stalled")

  // Pending and a nonzero level are set and cleared together.
  `ASSERT_AT(a_pending_level, event_pending_o == (alarm_level_o != LVL_NONE), "pending and level disagree")

  // A raised alarm is pending and recorded as the last event.
  `ASSERT_ON_OUT(a_raise_recorded, raised_event_o == EVT_NONE || (event_pending_o && last_event_type_o == raised_event_o), "raised alarm not recorded")

  // A recovery failure alarm always leaves the critical level behind.
  `ASSERT_ON_OUT(a_recov_crit, raised_event_o != EVT_RECOV_FAIL || alarm_level_o == LVL_CRIT, "recovery failure without critical level")

endmodule

bind resource_event_alarm_monitor ream_chk u_ream_chk (.*);

`default_nettype wire
